FILE: rtl/gitm_pkg.sv
// Shared types, constants and arithmetic helpers of the grid interpolated texture mapper.
`default_nettype none

package gitm_pkg;

   // Texture geometry: a square texture addressed as v * side + u.
   localparam int TEX_SIDE_LOG = 7;
   localparam int TEX_SIDE = 1 << TEX_SIDE_LOG;
   localparam int TEX_ADDR_W = 2 * TEX_SIDE_LOG;
   localparam int TEX_ENTRIES = TEX_SIDE * TEX_SIDE;
   localparam int TEXEL_W = 16;

   // Bit positions where the texture coordinates start in the 16.16 values.
   localparam int U_LSB = 17;
   localparam int V_LSB = 15;

   // Screen block geometry: eight by eight pixels.
   localparam int BLOCK_LOG = 3;
   localparam int BLOCK_SIDE = 1 << BLOCK_LOG;
   localparam int PIX_CNT_W = 2 * BLOCK_LOG;

   // Seam limit register.
   localparam int LIMIT_W = 8;
   localparam logic [LIMIT_W-1:0] SEAM_LIMIT_RESET = 8'd100;

   // Default depth of the job queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Command codes.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RENDER = 1'b1;

   // One input item.
   typedef struct packed {
      logic                  cmd;
      logic [TEX_ADDR_W-1:0] texel_addr;
      logic [TEXEL_W-1:0]    texel_data;
      logic signed [31:0]    angle_top_left;
      logic signed [31:0]    depth_top_left;
      logic signed [31:0]    angle_bottom_left;
      logic signed [31:0]    depth_bottom_left;
      logic signed [31:0]    angle_top_right;
      logic signed [31:0]    depth_top_right;
      logic signed [31:0]    angle_bottom_right;
      logic signed [31:0]    depth_bottom_right;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic [BLOCK_LOG-1:0] pixel_row;
      logic [BLOCK_LOG-1:0] pixel_col;
      logic [TEXEL_W-1:0]   texel;
      logic                 last;
   } rsp_item_type;

   // A classified job handed from the front to the back.
   typedef struct packed {
      logic                  cmd;
      logic [TEX_ADDR_W-1:0] texel_addr;
      logic [TEXEL_W-1:0]    texel_data;
      logic [31:0]           angle_left;
      logic [31:0]           depth_left;
      logic [31:0]           angle_right;
      logic [31:0]           depth_right;
      logic [31:0]           angle_left_step;
      logic [31:0]           depth_left_step;
      logic [31:0]           angle_right_step;
      logic [31:0]           depth_right_step;
   } job_type;

   // True when the integer part of |later - base|, truncated toward zero, exceeds the limit.
   function automatic logic seam_jump(input logic [31:0] later, input logic [31:0] base,
                                      input logic [LIMIT_W-1:0] limit);
      logic [32:0] diff;
      logic [32:0] mag;
      diff = {later[31], later} - {base[31], base};
      mag = diff[32] ? (33'd0 - diff) : diff;
      return mag[32:16] > {9'd0, limit};
   endfunction

   // (hi - lo) / BLOCK_SIDE with truncation toward zero, kept to 32 bits.
   function automatic logic [31:0] trunc_step(input logic [31:0] hi, input logic [31:0] lo);
      logic [32:0] diff;
      logic [33:0] adj;
      diff = {hi[31], hi} - {lo[31], lo};
      adj = {diff[32], diff} + (diff[32] ? 34'(BLOCK_SIDE - 1) : 34'd0);
      return {adj[33], adj[33:BLOCK_LOG]};
   endfunction

   // (hi - lo) shifted right arithmetically by the block log, kept to 32 bits.
   function automatic logic [31:0] floor_step(input logic [31:0] hi, input logic [31:0] lo);
      logic [32:0] diff;
      diff = {hi[31], hi} - {lo[31], lo};
      return {{(BLOCK_LOG - 1){diff[32]}}, diff[32:BLOCK_LOG]};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/gitm_front.sv
// Front end: accepts items, applies the seam fix and works out the edge steps of a block.
`default_nettype none

module gitm_front (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   output logic                           busy,
   input  gitm_pkg::req_item_type         req_item,
   input  wire [gitm_pkg::LIMIT_W-1:0]    seam_limit,
   input  wire                            queue_full,
   output logic                           push,
   output gitm_pkg::job_type              job
);

   typedef enum logic [4:0] {
      F_IDLE = 5'b00001,
      F_FIX1 = 5'b00010,
      F_FIX2 = 5'b00100,
      F_STEP = 5'b01000,
      F_PUSH = 5'b10000
   } front_state_type;

   front_state_type        state_ff, state_in;
   gitm_pkg::req_item_type item_ff, item_in;
   logic [31:0]            a0i_ff, a0i_in;
   logic [31:0]            z0i_ff, z0i_in;
   logic [31:0]            a1i_ff, a1i_in;
   logic [31:0]            z1i_ff, z1i_in;

   // Sequencer: capture, fix left and top-right, fix bottom-right, steps, hand over.
   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      a0i_in = a0i_ff;
      z0i_in = z0i_ff;
      a1i_in = a1i_ff;
      z1i_in = z1i_ff;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               item_in = req_item;
               state_in = (req_item.cmd == gitm_pkg::CMD_RENDER) ? F_FIX1 : F_PUSH;
            end
         end
         F_FIX1: begin
            if (gitm_pkg::seam_jump(item_ff.angle_bottom_left, item_ff.angle_top_left,
                                    seam_limit)) begin
               item_in.angle_bottom_left = item_ff.angle_top_left;
            end
            if (gitm_pkg::seam_jump(item_ff.angle_top_right, item_ff.angle_top_left,
                                    seam_limit)) begin
               item_in.angle_top_right = item_ff.angle_top_left;
            end
            state_in = F_FIX2;
         end
         F_FIX2: begin
            // Bottom-right is judged against the already fixed top-right.
            if (gitm_pkg::seam_jump(item_ff.angle_bottom_right, item_ff.angle_top_right,
                                    seam_limit)) begin
               item_in.angle_bottom_right = item_ff.angle_top_right;
            end
            state_in = F_STEP;
         end
         F_STEP: begin
            a0i_in = gitm_pkg::trunc_step(item_ff.angle_bottom_left, item_ff.angle_top_left);
            z0i_in = gitm_pkg::trunc_step(item_ff.depth_bottom_left, item_ff.depth_top_left);
            a1i_in = gitm_pkg::trunc_step(item_ff.angle_bottom_right, item_ff.angle_top_right);
            z1i_in = gitm_pkg::trunc_step(item_ff.depth_bottom_right, item_ff.depth_top_right);
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!queue_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // Handshake and job assembly.
   assign busy = (state_ff != F_IDLE);
   assign push = (state_ff == F_PUSH) && !queue_full;

   always_comb begin
      job.cmd = item_ff.cmd;
      job.texel_addr = item_ff.texel_addr;
      job.texel_data = item_ff.texel_data;
      job.angle_left = item_ff.angle_top_left;
      job.depth_left = item_ff.depth_top_left;
      job.angle_right = item_ff.angle_top_right;
      job.depth_right = item_ff.depth_top_right;
      job.angle_left_step = a0i_ff;
      job.depth_left_step = z0i_ff;
      job.angle_right_step = a1i_ff;
      job.depth_right_step = z1i_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      a0i_ff <= a0i_in;
      z0i_ff <= z0i_in;
      a1i_ff <= a1i_in;
      z1i_ff <= z1i_in;
   end

endmodule

`default_nettype wire

FILE: rtl/gitm_queue.sv
// Short job queue that decouples the front end from the render back end.
`default_nettype none

module gitm_queue #(
   parameter int Depth = gitm_pkg::QUEUE_DEPTH
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  gitm_pkg::job_type  push_job,
   output logic               full,
   input  wire                pop,
   output gitm_pkg::job_type  pop_job,
   output logic               empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

   gitm_pkg::job_type entries_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign pop_job = entries_ff[rd_ptr_ff];

   // Pointer and fill count update; a transfer in and out in one cycle keeps the count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : PtrW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : PtrW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CntW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CntW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/gitm_back.sv
// Back end: texture memory, texture loads and the row by row walk over a block.
`default_nettype none

module gitm_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     queue_empty,
   input  gitm_pkg::job_type       job,
   output logic                    pop,
   output logic                    rsp_valid,
   output gitm_pkg::rsp_item_type  rsp_item
);

   localparam int PW = gitm_pkg::PIX_CNT_W;
   localparam int BL = gitm_pkg::BLOCK_LOG;
   localparam int SL = gitm_pkg::TEX_SIDE_LOG;

   typedef enum logic [2:0] {
      B_IDLE  = 3'b001,
      B_SETUP = 3'b010,
      B_PIXEL = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;

   // Edge accumulators and their per-row steps.
   logic [31:0] l_ang_ff, l_ang_in;
   logic [31:0] l_dep_ff, l_dep_in;
   logic [31:0] r_ang_ff, r_ang_in;
   logic [31:0] r_dep_ff, r_dep_in;
   logic [31:0] a0i_ff, a0i_in;
   logic [31:0] z0i_ff, z0i_in;
   logic [31:0] a1i_ff, a1i_in;
   logic [31:0] z1i_ff, z1i_in;

   // Pixel accumulators, their steps and the steps of the coming row.
   logic [31:0] a_ff, a_in;
   logic [31:0] z_ff, z_in;
   logic [31:0] ai_ff, ai_in;
   logic [31:0] zi_ff, zi_in;
   logic [31:0] nai_ff, nai_in;
   logic [31:0] nzi_ff, nzi_in;
   logic [PW-1:0] cnt_ff, cnt_in;

   // Texture memory and read pipeline.
   logic [gitm_pkg::TEXEL_W-1:0]    tex_mem [gitm_pkg::TEX_ENTRIES];
   logic                            mem_we;
   logic [gitm_pkg::TEX_ADDR_W-1:0] mem_raddr;
   logic [gitm_pkg::TEXEL_W-1:0]    mem_rdata_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BL-1:0]        row_ff, row_in;
   logic [BL-1:0]        col_ff, col_in;
   logic                 last_ff, last_in;

   // The texel address comes straight from the pixel accumulators.
   assign mem_raddr = {z_ff[gitm_pkg::V_LSB +: SL], a_ff[gitm_pkg::U_LSB +: SL]};

   // Walk sequencer.
   always_comb begin
      state_in = state_ff;
      pop = 1'b0;
      mem_we = 1'b0;
      l_ang_in = l_ang_ff;
      l_dep_in = l_dep_ff;
      r_ang_in = r_ang_ff;
      r_dep_in = r_dep_ff;
      a0i_in = a0i_ff;
      z0i_in = z0i_ff;
      a1i_in = a1i_ff;
      z1i_in = z1i_ff;
      a_in = a_ff;
      z_in = z_ff;
      ai_in = ai_ff;
      zi_in = zi_ff;
      nai_in = nai_ff;
      nzi_in = nzi_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (job.cmd == gitm_pkg::CMD_RENDER) begin
                  l_ang_in = job.angle_left;
                  l_dep_in = job.depth_left;
                  r_ang_in = job.angle_right;
                  r_dep_in = job.depth_right;
                  a0i_in = job.angle_left_step;
                  z0i_in = job.depth_left_step;
                  a1i_in = job.angle_right_step;
                  z1i_in = job.depth_right_step;
                  state_in = B_SETUP;
               end else begin
                  mem_we = 1'b1;
               end
            end
         end
         B_SETUP: begin
            // First row starts here; edges move on to the second row.
            a_in = l_ang_ff;
            z_in = l_dep_ff;
            ai_in = gitm_pkg::floor_step(r_ang_ff, l_ang_ff);
            zi_in = gitm_pkg::floor_step(r_dep_ff, l_dep_ff);
            l_ang_in = l_ang_ff + a0i_ff;
            l_dep_in = l_dep_ff + z0i_ff;
            r_ang_in = r_ang_ff + a1i_ff;
            r_dep_in = r_dep_ff + z1i_ff;
            cnt_in = '0;
            state_in = B_PIXEL;
         end
         B_PIXEL: begin
            // The next row's pixel steps are formed while this row is walked.
            nai_in = gitm_pkg::floor_step(r_ang_ff, l_ang_ff);
            nzi_in = gitm_pkg::floor_step(r_dep_ff, l_dep_ff);
            a_in = a_ff + ai_ff;
            z_in = z_ff + zi_ff;
            cnt_in = PW'(cnt_ff + 1'b1);
            if (cnt_ff[BL-1:0] == {BL{1'b1}}) begin
               a_in = l_ang_ff;
               z_in = l_dep_ff;
               ai_in = nai_ff;
               zi_in = nzi_ff;
               l_ang_in = l_ang_ff + a0i_ff;
               l_dep_in = l_dep_ff + z0i_ff;
               r_ang_in = r_ang_ff + a1i_ff;
               r_dep_in = r_dep_ff + z1i_ff;
            end
            if (cnt_ff == {PW{1'b1}}) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Result tags travel alongside the memory read.
   assign rsp_valid_in = (state_ff == B_PIXEL);
   assign row_in = cnt_ff[PW-1:BL];
   assign col_in = cnt_ff[BL-1:0];
   assign last_in = (cnt_ff == {PW{1'b1}});

   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_item.pixel_row = row_ff;
      rsp_item.pixel_col = col_ff;
      rsp_item.texel = mem_rdata_ff;
      rsp_item.last = last_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      l_ang_ff <= l_ang_in;
      l_dep_ff <= l_dep_in;
      r_ang_ff <= r_ang_in;
      r_dep_ff <= r_dep_in;
      a0i_ff <= a0i_in;
      z0i_ff <= z0i_in;
      a1i_ff <= a1i_in;
      z1i_ff <= z1i_in;
      a_ff <= a_in;
      z_ff <= z_in;
      ai_ff <= ai_in;
      zi_ff <= zi_in;
      nai_ff <= nai_in;
      nzi_ff <= nzi_in;
      row_ff <= row_in;
      col_ff <= col_in;
      last_ff <= last_in;
   end

   // Texture memory: one write port for loads, one registered read port for the walk.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tex_mem[job.texel_addr] <= job.texel_data;
      end
      mem_rdata_ff <= tex_mem[mem_raddr];
   end

`ifndef SYNTHESIS
   // The last texel of a block is always the bottom-right pixel.
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last |-> rsp_item.pixel_row == {BL{1'b1}}
                                      && rsp_item.pixel_col == {BL{1'b1}})
      else $error("last flag away from the bottom-right pixel");

   // A texel is shown in the cycle after every pixel step.
   a_rsp_follows_pixel: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_PIXEL |=> rsp_valid)
      else $error("pixel step without a texel transfer");

   // Jobs leave the queue only while the walk is idle.
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == B_IDLE && !queue_empty)
      else $error("job taken while busy or from an empty queue");

   // After the last texel the walk returns to idle.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_PIXEL && cnt_ff == {PW{1'b1}} |=> state_ff == B_IDLE)
      else $error("walk did not end after the last pixel");
`endif

endmodule

`default_nettype wire

FILE: rtl/grid_interpolated_texture_mapper_top.sv
// Top level of the grid interpolated texture mapper: front end, job queue and back end.
`default_nettype none

// Usage
// Input: an item is transferred at a clock edge with start high and busy low. A load item
// (cmd 0) writes texel_data to texel_addr of the texture memory. A render item (cmd 1) brings
// the four corner angles and depths of an 8x8 block and yields 64 texels, row by row.
// Results: rsp_valid marks one texel on rsp_item for a single cycle; the receiver cannot
// stall, so every marked cycle is a transfer. last is set on the 64th texel of a block.
// Configuration: csr_we writes csr_wdata into the seam jump limit; write only while idle.
// Flow: the front end takes a render item through capture, seam fix, step and hand-over
// states and a load through capture and hand-over; busy stays high until the queue takes it.
// The back end fetches one job from the queue at a time, only when idle; for a render it
// does a setup and then one texture read per pixel, while a load reaches the memory as it
// is fetched. The back end's single texture read port sets the sustained rate of blocks.
// busy stays low while the front end is free; a job queue lets the front end work ahead.
// Reset: clears the control state and loads the seam limit with 100; the texture memory
// holds nothing defined until written.
module grid_interpolated_texture_mapper_top #(
   parameter int QueueDepth = gitm_pkg::QUEUE_DEPTH
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   output logic                           busy,
   input  gitm_pkg::req_item_type         req_item,
   output logic                           rsp_valid,
   output gitm_pkg::rsp_item_type         rsp_item,
   input  wire                            csr_we,
   input  wire [gitm_pkg::LIMIT_W-1:0]    csr_wdata
);

   logic [gitm_pkg::LIMIT_W-1:0] seam_limit_ff;
   logic                         push;
   logic                         pop;
   logic                         queue_full;
   logic                         queue_empty;
   gitm_pkg::job_type            push_job;
   gitm_pkg::job_type            pop_job;

   // Seam limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         seam_limit_ff <= gitm_pkg::SEAM_LIMIT_RESET;
      end else if (csr_we) begin
         seam_limit_ff <= csr_wdata;
      end
   end

   gitm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .seam_limit (seam_limit_ff),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   gitm_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   gitm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .job         (pop_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

endmodule

`default_nettype wire

FILE: test/gitm_texel_checker.sv
// Checker for the texture mapper: predicts the texels of every render transfer and compares.
module gitm_texel_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  gitm_pkg::req_item_type       req_item,
   input  logic                         rsp_valid,
   input  gitm_pkg::rsp_item_type       rsp_item,
   input  logic                         csr_we,
   input  logic [gitm_pkg::LIMIT_W-1:0] csr_wdata,
   output int                           mismatches,
   output int                           texels_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow of the texture memory and of the seam limit register.
   logic [gitm_pkg::TEXEL_W-1:0] texture_copy [gitm_pkg::TEX_ENTRIES];
   logic [gitm_pkg::LIMIT_W-1:0] seam_limit;

   // Texels still owed by the block, oldest first.
   gitm_pkg::rsp_item_type expected_texels [$];
   gitm_pkg::rsp_item_type want;

   initial begin
      mismatches = 0;
      texels_pending = 0;
      seam_limit = gitm_pkg::SEAM_LIMIT_RESET;
   end

   // A corner is a seam when the whole part of its jump, truncated toward zero, is over the limit.
   function automatic logic seam_crossed(input longint later, input longint anchor,
                                         input logic [gitm_pkg::LIMIT_W-1:0] lim);
      longint gap;
      gap = later - anchor;
      if (gap < 0) gap = -gap;
      return (gap >>> 16) > longint'(lim);
   endfunction

   // Edge step per row: exact difference divided with truncation toward zero.
   function automatic logic [31:0] edge_step(input longint hi, input longint lo);
      longint q;
      q = (hi - lo) / gitm_pkg::BLOCK_SIDE;
      return q[31:0];
   endfunction

   // Pixel step within a row: exact difference, arithmetic shift (rounds toward minus infinity).
   function automatic logic [31:0] pixel_step(input logic [31:0] hi, input logic [31:0] lo);
      longint diff;
      diff = longint'($signed(hi)) - longint'($signed(lo));
      diff = diff >>> gitm_pkg::BLOCK_LOG;
      return diff[31:0];
   endfunction

   // Work out the 64 texels of one render transfer, row by row.
   task automatic predict_block(input gitm_pkg::req_item_type it);
      longint a_tl, a_bl, a_tr, a_br;
      logic [31:0] left_a, left_z, right_a, right_z;
      logic [31:0] left_a_step, left_z_step, right_a_step, right_z_step;
      logic [31:0] a, z, a_step, z_step;
      gitm_pkg::rsp_item_type px;
      a_tl = longint'(it.angle_top_left);
      a_bl = longint'(it.angle_bottom_left);
      a_tr = longint'(it.angle_top_right);
      a_br = longint'(it.angle_bottom_right);
      // Bottom-right is judged against top-right after that one has been fixed.
      if (seam_crossed(a_bl, a_tl, seam_limit)) a_bl = a_tl;
      if (seam_crossed(a_tr, a_tl, seam_limit)) a_tr = a_tl;
      if (seam_crossed(a_br, a_tr, seam_limit)) a_br = a_tr;
      left_a = a_tl[31:0];
      left_z = it.depth_top_left;
      right_a = a_tr[31:0];
      right_z = it.depth_top_right;
      left_a_step = edge_step(a_bl, a_tl);
      left_z_step = edge_step(longint'(it.depth_bottom_left), longint'(it.depth_top_left));
      right_a_step = edge_step(a_br, a_tr);
      right_z_step = edge_step(longint'(it.depth_bottom_right), longint'(it.depth_top_right));
      for (int row = 0; row < gitm_pkg::BLOCK_SIDE; row++) begin
         a = left_a;
         z = left_z;
         a_step = pixel_step(right_a, left_a);
         z_step = pixel_step(right_z, left_z);
         for (int col = 0; col < gitm_pkg::BLOCK_SIDE; col++) begin
            px.pixel_row = gitm_pkg::BLOCK_LOG'(row);
            px.pixel_col = gitm_pkg::BLOCK_LOG'(col);
            px.texel = texture_copy[{z[gitm_pkg::V_LSB +: gitm_pkg::TEX_SIDE_LOG],
                                     a[gitm_pkg::U_LSB +: gitm_pkg::TEX_SIDE_LOG]}];
            px.last = (row == gitm_pkg::BLOCK_SIDE - 1) && (col == gitm_pkg::BLOCK_SIDE - 1);
            expected_texels.push_back(px);
            a += a_step;
            z += z_step;
         end
         // All four accumulators wrap at 32 bits.
         left_a += left_a_step;
         left_z += left_z_step;
         right_a += right_a_step;
         right_z += right_z_step;
      end
   endtask

   task automatic check_field(input string name, input logic [gitm_pkg::TEXEL_W-1:0] exp_v,
                              input logic [gitm_pkg::TEXEL_W-1:0] got_v);
      if (got_v !== exp_v) begin
         mismatches++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
      end
   endtask

   // Results are checked before this edge's request transfer is predicted; a render's first
   // texel cannot leave in the cycle it is taken.
   always @(posedge clock) begin
      if (reset) begin
         seam_limit = gitm_pkg::SEAM_LIMIT_RESET;
         expected_texels.delete();
      end else begin
         if (csr_we) seam_limit = csr_wdata;
         if (rsp_valid) begin
            if (expected_texels.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected texel: expected none, actual row %0d col %0d %h %b",
                        $time, rsp_item.pixel_row, rsp_item.pixel_col, rsp_item.texel,
                        rsp_item.last);
            end else begin
               want = expected_texels.pop_front();
               check_field("pixel_row", gitm_pkg::TEXEL_W'(want.pixel_row),
                           gitm_pkg::TEXEL_W'(rsp_item.pixel_row));
               check_field("pixel_col", gitm_pkg::TEXEL_W'(want.pixel_col),
                           gitm_pkg::TEXEL_W'(rsp_item.pixel_col));
               check_field("texel", want.texel, rsp_item.texel);
               check_field("last", gitm_pkg::TEXEL_W'(want.last),
                           gitm_pkg::TEXEL_W'(rsp_item.last));
            end
         end
         if (start && !busy) begin
            if (req_item.cmd == gitm_pkg::CMD_LOAD)
               texture_copy[req_item.texel_addr] = req_item.texel_data;
            else
               predict_block(req_item);
         end
      end
      texels_pending = expected_texels.size();
   end

endmodule

FILE: test/grid_interpolated_texture_mapper_top_tb.sv
// Testbench top: drives load and render transfers and seam limit writes, and gives the verdict.
module grid_interpolated_texture_mapper_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600_000;
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASE_ITEMS = 91;
   localparam int REQ_W = $bits(gitm_pkg::req_item_type);

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   gitm_pkg::req_item_type       req_item = '0;
   logic                         rsp_valid;
   gitm_pkg::rsp_item_type       rsp_item;
   logic                         csr_we = 1'b0;
   logic [gitm_pkg::LIMIT_W-1:0] csr_wdata = '0;
   int                           mismatches;
   int                           texels_pending;
   int                           cycle_count = 0;

   always #5 clock = ~clock;

   grid_interpolated_texture_mapper_top dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   gitm_texel_checker checker_inst (.*);

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic gitm_pkg::req_item_type texel_load(
         input logic [gitm_pkg::TEX_ADDR_W-1:0] addr,
         input logic [gitm_pkg::TEXEL_W-1:0] data);
      gitm_pkg::req_item_type it;
      it = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom});
      it.cmd = gitm_pkg::CMD_LOAD;
      it.texel_addr = addr;
      it.texel_data = data;
      return it;
   endfunction

   // Corners in the order top-left, bottom-left, top-right, bottom-right; angle then depth.
   function automatic gitm_pkg::req_item_type block_item(input logic [31:0] atl, ztl, abl, zbl,
                                                         input logic [31:0] atr, ztr, abr, zbr);
      gitm_pkg::req_item_type it;
      it.cmd = gitm_pkg::CMD_RENDER;
      it.texel_addr = gitm_pkg::TEX_ADDR_W'($urandom);
      it.texel_data = gitm_pkg::TEXEL_W'($urandom);
      it.angle_top_left = atl;
      it.depth_top_left = ztl;
      it.angle_bottom_left = abl;
      it.depth_bottom_left = zbl;
      it.angle_top_right = atr;
      it.depth_top_right = ztr;
      it.angle_bottom_right = abr;
      it.depth_bottom_right = zbr;
      return it;
   endfunction

   // Corner jumps: mostly small, some right at the seam limit, a few anywhere at all.
   function automatic logic [31:0] corner_offset(input logic [gitm_pkg::LIMIT_W-1:0] lim);
      logic [31:0] mag;
      case ($urandom_range(9))
         0: mag = $urandom;
         1, 2: mag = {16'(lim) + 16'($urandom_range(1)), 16'($urandom)};
         default: mag = $urandom_range(32'h00FF_FFFF);
      endcase
      return $urandom_range(1) ? -mag : mag;
   endfunction

   function automatic gitm_pkg::req_item_type random_item(
         input logic [gitm_pkg::LIMIT_W-1:0] lim);
      logic [31:0] base_a, base_z, right_a, right_z;
      base_a = $urandom;
      base_z = $urandom;
      right_a = base_a + corner_offset(lim);
      right_z = base_z + corner_offset(lim);
      if ($urandom_range(99) < 40)
         return texel_load(gitm_pkg::TEX_ADDR_W'($urandom), gitm_pkg::TEXEL_W'($urandom));
      return block_item(base_a, base_z, base_a + corner_offset(lim), base_z + corner_offset(lim),
                        right_a, right_z, right_a + corner_offset(lim),
                        right_z + corner_offset(lim));
   endfunction

   // Offer one item and hold it until the transfer; busy is sampled at the edge itself.
   task automatic send_item(input gitm_pkg::req_item_type it);
      @(negedge clock);
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
   endtask

   // Sender gaps with junk on the request bus.
   task automatic idle_gap(input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         req_item <= random_item(8'($urandom));
      end
   endtask

   // The limit is changed only with no texel owed and time for any queued loads to drain.
   task automatic write_seam_limit(input logic [gitm_pkg::LIMIT_W-1:0] value);
      @(negedge clock);
      start <= 1'b0;
      while (texels_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input logic [gitm_pkg::LIMIT_W-1:0] lim, input int idle_pct);
      write_seam_limit(lim);
      repeat (PHASE_ITEMS) begin
         idle_gap(idle_pct);
         send_item(random_item(lim));
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Fill the whole texture so that no render reads an unwritten texel.
      for (int addr = 0; addr < gitm_pkg::TEX_ENTRIES; addr++)
         send_item(texel_load(gitm_pkg::TEX_ADDR_W'(addr), gitm_pkg::TEXEL_W'($urandom)));

      // Load extremes; the all-zero block right after reads back the new texel at address 0.
      send_item(texel_load(14'h3FFF, 16'h0000));
      send_item(texel_load(14'h2AAA, 16'h5555));
      send_item(texel_load(14'h1555, 16'hAAAA));
      send_item(texel_load(14'h0000, 16'hFFFF));
      send_item(block_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
      send_item(block_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_item(block_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      // Full-scale corner spread: bottom-left and top-right angles are seams and the depth accumulators wrap.
      send_item(block_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
      // Jumps of just over and just under the reset limit, upward then downward.
      send_item(block_item(32'h0000_0000, 32'h0000_0000, 32'h0065_0000, 32'h0040_0000,
                           32'h0064_FFFF, 32'h0010_0000, 32'h00C9_FFFF, 32'h0050_0000));
      send_item(block_item(32'h0100_0000, 32'hFFF0_0000, 32'h009B_0000, 32'hFF80_0000,
                           32'h009B_0001, 32'h0000_0000, 32'h0036_0002, 32'hFFC0_0000));
      // Bottom-right is fine against the repaired top-right but not against the original.
      send_item(block_item(32'h0000_0000, 32'h0000_0000, 32'h0010_0000, 32'h0020_0000,
                           32'h00C8_0000, 32'h0010_0000, 32'h0032_0000, 32'h0030_0000));
      // Small negative differences where truncation and flooring part ways.
      send_item(block_item(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFF9, 32'hFFFF_FFF1,
                           32'hFFFF_FFF7, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h0000_0009));
      // Values at the top of the range whose depth difference crosses the sign boundary.
      send_item(block_item(32'h7FF0_0000, 32'h7FFF_FFF8, 32'h7FFF_FFFF, 32'h8000_0007,
                           32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));

      // With a zero limit only jumps of less than one whole unit survive.
      write_seam_limit(8'd0);
      send_item(block_item(32'h1234_0000, 32'h0300_0000, 32'h1234_FFFF, 32'h0380_0000,
                           32'h1235_0000, 32'h0340_0000, 32'h1233_0001, 32'h02C0_0000));
      send_item(block_item(32'h1234_0000, 32'hF000_0000, 32'h1233_0000, 32'hF010_0000,
                           32'h1233_0001, 32'hEFF0_0000, 32'h1234_0001, 32'hF020_0000));

      // Largest limit: 255 whole units pass, 256 do not.
      write_seam_limit(8'd255);
      send_item(block_item(32'h0000_0000, 32'h0000_0000, 32'h00FF_FFFF, 32'h0123_4567,
                           32'h0100_0000, 32'hFEDC_BA98, 32'hFF00_0000, 32'h0000_FFFF));
      send_item(block_item(32'h8000_0000, 32'h4000_0000, 32'h80FF_0000, 32'hC000_0000,
                           32'h7F01_0000, 32'h3FFF_FFFF, 32'h8000_0001, 32'hBFFF_FFFF));

      // Random phases: no gaps, heavy sender gaps, no gaps, moderate sender gaps.
      run_phase(8'd0, 0);
      run_phase(8'($urandom_range(1, 254)), 74);
      run_phase(8'd255, 0);
      run_phase(8'($urandom_range(1, 254)), 36);

      @(negedge clock);
      start <= 1'b0;
      while (texels_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && texels_pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
